>>> rtl/ansc_pkg.sv
`timescale 1ns / 1ps
// shared constants, event type and helper types for the annex b nal unit scanner
package ansc_pkg;

    localparam int unsigned MAX_UNIT_BYTES = 16777216;
    localparam int POS_W   = 25;
    localparam int OFS_W   = 24;
    localparam int LEN_W   = 24;
    localparam int TOTAL_W = 25;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [1:0] CODEC_H264 = 2'd0;
    localparam logic [1:0] CODEC_H265 = 2'd1;

    // register index taken from the word address
    localparam logic REG_CODEC_MODE = 1'b0;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int TDATA_W = 96;

    typedef struct packed {
        logic             has_unit;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic [7:0]       header;
        logic             last;
        logic             overflow;
    } ansc_evt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ansc_fifo_stat_t;

endpackage

>>> rtl/ansc_front.sv
`timescale 1ns / 1ps
// byte scanner: start code detection and unit boundary tracking
module ansc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // byte_value
    input  logic                     s_tlast,   // last_byte
    input  ansc_pkg::ansc_fifo_stat_t fifo_stat,
    output logic                     evt_push,
    output ansc_pkg::ansc_evt_t      evt
);

    logic [ansc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [1:0]                 zrun_reg, zrun_next;
    logic                       start_reg, start_next;
    logic [ansc_pkg::OFS_W-1:0] begin_reg, begin_next;
    logic [7:0]                 hdr_reg, hdr_next;
    logic                       ovf_reg, ovf_next;

    logic                       acc;
    logic                       in_range;
    logic                       is_sc;
    logic                       unit_sc;
    logic                       unit_last;
    logic [7:0]                 hdr_eff;
    logic [ansc_pkg::POS_W-1:0] code_begin;
    logic [ansc_pkg::POS_W-1:0] pos_inc;
    logic [ansc_pkg::POS_W-1:0] end_pos;

    assign s_tready = !fifo_stat.full;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        in_range   = pos_reg < ansc_pkg::POS_W'(ansc_pkg::MAX_UNIT_BYTES);
        hdr_eff    = (start_reg && in_range && pos_reg[ansc_pkg::OFS_W-1:0] == begin_reg)
                     ? s_tdata : hdr_reg;
        is_sc      = in_range && s_tdata == 8'h01 && zrun_reg >= 2'd2;
        code_begin = pos_reg - {{(ansc_pkg::POS_W-2){1'b0}}, zrun_reg};
        pos_inc    = pos_reg + 1'b1;
        unit_sc    = is_sc && start_reg && ({1'b0, begin_reg} < code_begin);

        pos_next   = pos_reg;
        zrun_next  = zrun_reg;
        start_next = start_reg;
        begin_next = begin_reg;
        hdr_next   = hdr_eff;
        ovf_next   = ovf_reg;

        if (in_range) begin
            pos_next = pos_inc;
            if (is_sc) begin
                zrun_next = 2'd0;
                if (pos_inc < ansc_pkg::POS_W'(ansc_pkg::MAX_UNIT_BYTES)) begin
                    begin_next = pos_inc[ansc_pkg::OFS_W-1:0];
                    start_next = 1'b1;
                end else begin
                    start_next = 1'b0;
                end
            end else if (s_tdata == 8'h00) begin
                if (zrun_reg != 2'd3) begin
                    zrun_next = zrun_reg + 1'b1;
                end
            end else begin
                zrun_next = 2'd0;
            end
        end else begin
            ovf_next = 1'b1;
        end

        // open unit runs to the end of the access unit
        unit_last = s_tlast && start_next && ({1'b0, begin_next} < pos_next);

        end_pos          = unit_sc ? code_begin : pos_next;
        evt.has_unit     = unit_sc || unit_last;
        evt.offset       = unit_sc ? begin_reg : begin_next;
        evt.length       = ansc_pkg::LEN_W'(end_pos - {1'b0, evt.offset});
        evt.header       = hdr_eff;
        evt.last         = s_tlast;
        evt.overflow     = ovf_next;
        evt_push         = acc && (unit_sc || unit_last || s_tlast);

        if (s_tlast) begin
            pos_next   = '0;
            zrun_next  = '0;
            start_next = 1'b0;
            begin_next = '0;
            hdr_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            zrun_reg  <= '0;
            start_reg <= 1'b0;
            begin_reg <= '0;
            hdr_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (acc) begin
            pos_reg   <= pos_next;
            zrun_reg  <= zrun_next;
            start_reg <= start_next;
            begin_reg <= begin_next;
            hdr_reg   <= hdr_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

>>> rtl/ansc_fifo.sv
`timescale 1ns / 1ps
// small event queue between the byte scanner and the record builder
module ansc_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  ansc_pkg::ansc_evt_t       push_evt,
    input  logic                      pop,
    output ansc_pkg::ansc_evt_t       head_evt,
    output ansc_pkg::ansc_fifo_stat_t stat
);

    ansc_pkg::ansc_evt_t          mem [ansc_pkg::FIFO_DEPTH];
    logic [ansc_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ansc_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [ansc_pkg::FIFO_AW:0]   count_reg, count_next;

    assign head_evt   = mem[rd_ptr_reg];
    assign stat.full  = count_reg == (ansc_pkg::FIFO_AW+1)'(ansc_pkg::FIFO_DEPTH);
    assign stat.empty = count_reg == '0;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

>>> rtl/ansc_back.sv
`timescale 1ns / 1ps
// record builder: type and drop decision, sample size sum, output register
module ansc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [1:0]                codec_mode,
    input  ansc_pkg::ansc_evt_t       evt,
    input  ansc_pkg::ansc_fifo_stat_t fifo_stat,
    output logic                      evt_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ansc_pkg::TDATA_W-1:0] m_tdata,
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic                           m_tvalid_reg;
    logic [ansc_pkg::TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;
    logic [ansc_pkg::TOTAL_W-1:0]   kept_reg, kept_next;

    logic [5:0]                     unit_type;
    logic                           drop;
    logic [ansc_pkg::TOTAL_W-1:0]   add;
    logic [ansc_pkg::TOTAL_W:0]     sum;
    logic [ansc_pkg::TOTAL_W-1:0]   kept_new;
    logic [ansc_pkg::TOTAL_W-1:0]   sample_bytes;

    assign evt_pop  = !fifo_stat.empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        if (codec_mode == ansc_pkg::CODEC_H265) begin
            unit_type = evt.header[6:1];
        end else begin
            unit_type = {1'b0, evt.header[4:0]};
        end

        case (codec_mode)
            ansc_pkg::CODEC_H264: drop = unit_type == 6'd7 || unit_type == 6'd8;
            ansc_pkg::CODEC_H265: drop = unit_type == 6'd32 || unit_type == 6'd33
                                         || unit_type == 6'd34;
            default:              drop = 1'b0;
        endcase

        add = {1'b0, evt.length} + ansc_pkg::TOTAL_W'(4);
        sum = {1'b0, kept_reg} + {1'b0, add};
        if (evt.has_unit && !drop) begin
            kept_new = sum[ansc_pkg::TOTAL_W] ? ansc_pkg::TOTAL_MAX
                                              : sum[ansc_pkg::TOTAL_W-1:0];
        end else begin
            kept_new = kept_reg;
        end
        kept_next    = evt.last ? '0 : kept_new;
        sample_bytes = kept_new;

        m_tdata_next = '0;
        if (evt.has_unit) begin
            m_tdata_next[23:0]  = evt.offset;
            m_tdata_next[47:24] = evt.length;
            m_tdata_next[55:48] = evt.header;
            m_tdata_next[61:56] = unit_type;
            m_tdata_next[62]    = drop;
        end
        if (evt.last) begin
            m_tdata_next[87:63] = sample_bytes;
            m_tdata_next[88]    = sample_bytes == '0;
            m_tdata_next[89]    = evt.overflow;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            kept_reg     <= '0;
        end else if (evt_pop) begin
            m_tvalid_reg <= 1'b1;
            kept_reg     <= kept_next;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= evt.has_unit;
            m_tlast_reg <= evt.last;
        end
    end

endmodule

>>> rtl/annexb_nal_unit_scanner_core.sv
`timescale 1ns / 1ps
// top level of the annex b nal unit scanner with its register port
// Takes one byte of an access unit per cycle on the s_ stream, with tlast on
// the final byte, and sustains one byte per clock. The byte scanner forms each
// event combinationally from its state registers; each byte that completes a
// unit or closes the access unit puts one event in a four-entry queue, from
// which the record builder fills a single output register, so s_tready only
// drops when the queue is full while the m_ side stalls. A result passes
// through the queue and then the output register. m_tuser marks a record that
// carries a nal unit, m_tlast the record that closes the access unit.
// codec_mode (address 0) must be written only while no records are outstanding.
module annexb_nal_unit_scanner_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] unit_offset, [47:24] unit_length, [55:48] unit_header,
    // [61:56] unit_type, [62] unit_dropped, [87:63] sample_bytes,
    // [88] sample_empty, [89] size_overflow, [95:90] zero
    output logic [95:0]  m_tdata,
    output logic         m_tuser,   // [0] unit_valid
    output logic         m_tlast,   // end_of_unit
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [1:0]                codec_mode_reg;
    logic                      evt_push;
    logic                      evt_pop;
    ansc_pkg::ansc_evt_t       push_evt;
    ansc_pkg::ansc_evt_t       head_evt;
    ansc_pkg::ansc_fifo_stat_t fifo_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ansc_pkg::REG_CODEC_MODE) ? {30'b0, codec_mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= ansc_pkg::CODEC_H264;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ansc_pkg::REG_CODEC_MODE) begin
            codec_mode_reg <= pwdata[1:0];
        end
    end

    ansc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_stat (fifo_stat),
        .evt_push  (evt_push),
        .evt       (push_evt)
    );

    ansc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (evt_push),
        .push_evt (push_evt),
        .pop      (evt_pop),
        .head_evt (head_evt),
        .stat     (fifo_stat)
    );

    ansc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .codec_mode (codec_mode_reg),
        .evt        (head_evt),
        .fifo_stat  (fifo_stat),
        .evt_pop    (evt_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/ansc_checker.sv
`timescale 1ns / 1ps
// port-level checks on the scanner's result stream, bound to the top level
module ansc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled record changed");

    // a record without a unit must be the closing one
    a_no_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("record carries neither unit nor close");

    a_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[62:0] == 63'd0)
        else $error("unit fields set without unit");

    a_close_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[95:63] == 33'd0)
        else $error("sample fields set before close");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[47:24] != 24'd0)
        else $error("empty unit reported");

endmodule

bind annexb_nal_unit_scanner_core ansc_checker u_ansc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/annexb_nal_unit_scanner_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the annex b nal unit scanner core
module annexb_nal_unit_scanner_core_tb;

    localparam logic [1:0] CODEC_PASS     = 2'd2;
    localparam logic [1:0] CODEC_PASS_ALT = 2'd3;

    localparam logic [5:0] NAL_H264_SPS = 6'd7;
    localparam logic [5:0] NAL_H264_PPS = 6'd8;
    localparam logic [5:0] NAL_H265_VPS = 6'd32;
    localparam logic [5:0] NAL_H265_SPS = 6'd33;
    localparam logic [5:0] NAL_H265_PPS = 6'd34;

    localparam int RANDOM_BYTES  = 600;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } au_byte_t;

    typedef struct packed {
        logic        unit;
        logic [23:0] ofs;
        logic [23:0] len;
        logic [7:0]  hdr;
        logic [5:0]  typ;
        logic        drop;
        logic        close;
        logic [24:0] total;
        logic        empty;
        logic        ovf;
    } nal_record_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;   // [7:0] byte_value
    logic         s_tlast = 1'b0; // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [23:0] unit_offset, [47:24] unit_length, [55:48] unit_header,
    // [61:56] unit_type, [62] unit_dropped, [87:63] sample_bytes,
    // [88] sample_empty, [89] size_overflow, [95:90] zero
    logic [95:0]  m_tdata;
    logic         m_tuser;        // [0] unit_valid
    logic         m_tlast;        // end_of_unit
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    annexb_nal_unit_scanner_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    au_byte_t    au_bytes_q[$];
    nal_record_t nal_records_q[$];

    logic        idle_on = 1'b1;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;

    // scanner shadow state
    logic [1:0]  sc_mode = ansc_pkg::CODEC_H264;
    logic [24:0] sc_pos = '0;
    logic [1:0]  sc_zeros = '0;
    logic        sc_open = 1'b0;
    logic [23:0] sc_begin = '0;
    logic [7:0]  sc_header = '0;
    logic [24:0] sc_kept = '0;
    logic        sc_ovf = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // unit fields for the nal unit ending just before stop; updates the kept total
    function automatic nal_record_t nal_fields(input logic [24:0] stop);
        nal_record_t r;
        logic [24:0] span;
        int unsigned add;
        r = '0;
        span = stop - {1'b0, sc_begin};
        r.unit = 1'b1;
        r.ofs  = sc_begin;
        r.len  = span[23:0];
        r.hdr  = sc_header;
        if (sc_mode == ansc_pkg::CODEC_H265) begin
            r.typ  = sc_header[6:1];
            r.drop = (r.typ == NAL_H265_VPS) || (r.typ == NAL_H265_SPS) ||
                     (r.typ == NAL_H265_PPS);
        end else begin
            r.typ  = {1'b0, sc_header[4:0]};
            r.drop = (sc_mode == ansc_pkg::CODEC_H264) &&
                     ((r.typ == NAL_H264_SPS) || (r.typ == NAL_H264_PPS));
        end
        if (!r.drop) begin
            add = span + 4;
            if (sc_kept > ansc_pkg::TOTAL_MAX - add) sc_kept = ansc_pkg::TOTAL_MAX;
            else sc_kept = sc_kept + add;
        end
        return r;
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic last);
        nal_record_t rec;
        logic [24:0] p;
        logic [24:0] code_at;
        logic        emit;
        rec  = '0;
        emit = 1'b0;
        p    = sc_pos;
        if (p >= ansc_pkg::MAX_UNIT_BYTES) begin
            sc_ovf = 1'b1;
        end else begin
            if (sc_open && p == {1'b0, sc_begin}) sc_header = b;
            if (b == 8'h01 && sc_zeros >= 2) begin
                code_at = p - sc_zeros;
                if (sc_open && {1'b0, sc_begin} < code_at) begin
                    rec  = nal_fields(code_at);
                    emit = 1'b1;
                end
                if (p + 1 < ansc_pkg::MAX_UNIT_BYTES) begin
                    sc_begin = p[23:0] + 24'd1;
                    sc_open  = 1'b1;
                end else begin
                    sc_open = 1'b0;
                end
                sc_zeros = '0;
            end else if (b == 8'h00) begin
                if (sc_zeros < 3) sc_zeros = sc_zeros + 2'd1;
            end else begin
                sc_zeros = '0;
            end
            sc_pos = p + 25'd1;
        end
        if (last) begin
            // unit still open runs to the end of the access unit
            if (sc_open && {1'b0, sc_begin} < sc_pos) rec = nal_fields(sc_pos);
            rec.close = 1'b1;
            rec.total = sc_kept;
            rec.empty = (sc_kept == 0);
            rec.ovf   = sc_ovf;
            emit      = 1'b1;
            sc_pos    = '0;
            sc_zeros  = '0;
            sc_open   = 1'b0;
            sc_begin  = '0;
            sc_header = '0;
            sc_kept   = '0;
            sc_ovf    = 1'b0;
        end
        if (emit) nal_records_q.insert(nal_records_q.size(), rec);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v,
                     act_v);
            mismatches++;
        end
    endfunction

    // byte source
    always @(posedge aclk) begin
        au_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (au_bytes_q.size() != 0 && !(idle_on && $urandom_range(99) < 21)) begin
                    nxt = au_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.value;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // record sink and checker
    always @(posedge aclk) begin
        nal_record_t exp_r;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_ack  <= hold_req;
        end else begin
            if (m_tvalid && m_tready) begin
                if (nal_records_q.size() == 0) begin
                    $display("%0t: unexpected record, expected none actual %h user %b last %b",
                             $realtime, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    exp_r = nal_records_q.pop_front();
                    check_field("unit_valid", exp_r.unit, m_tuser);
                    check_field("unit_offset", exp_r.ofs, m_tdata[23:0]);
                    check_field("unit_length", exp_r.len, m_tdata[47:24]);
                    check_field("unit_header", exp_r.hdr, m_tdata[55:48]);
                    check_field("unit_type", exp_r.typ, m_tdata[61:56]);
                    check_field("unit_dropped", exp_r.drop, m_tdata[62]);
                    check_field("end_of_unit", exp_r.close, m_tlast);
                    check_field("sample_bytes", exp_r.total, m_tdata[87:63]);
                    check_field("sample_empty", exp_r.empty, m_tdata[88]);
                    check_field("size_overflow", exp_r.ovf, m_tdata[89]);
                    check_field("tdata_pad", 32'd0, m_tdata[95:90]);
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 21);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_au(input logic [7:0] bytes[$]);
        au_byte_t item;
        for (int i = 0; i < bytes.size(); i++) begin
            item.value = bytes[i];
            item.last  = (i == bytes.size() - 1);
            au_bytes_q.insert(au_bytes_q.size(), item);
        end
    endtask

    // header biased toward parameter set types, laid out for the active codec
    function automatic logic [7:0] pick_header();
        logic [5:0] t;
        logic [7:0] r;
        r = 8'($urandom);
        case ($urandom_range(9))
            0: t = NAL_H264_SPS;
            1: t = NAL_H264_PPS;
            2: t = NAL_H265_VPS;
            3: t = NAL_H265_SPS;
            4: t = NAL_H265_PPS;
            default: t = 6'($urandom);
        endcase
        if (sc_mode == ansc_pkg::CODEC_H265) return {r[7], t, r[0]};
        return {r[7:5], t[4:0]};
    endfunction

    // builds one access unit, mostly well formed, returns its byte count
    task automatic queue_random_au(input int max_payload, output int n_bytes);
        logic [7:0] au[$];
        int nals;
        int plen;
        au = {};
        if ($urandom_range(99) < 20) begin
            // noise: zero-heavy random bytes
            repeat ($urandom_range(1, 30)) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: au.insert(au.size(), 8'h00);
                    4, 5:       au.insert(au.size(), 8'h01);
                    default:    au.insert(au.size(), 8'($urandom));
                endcase
            end
        end else begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3)) au.insert(au.size(), 8'($urandom));
            nals = $urandom_range(0, 6);
            for (int k = 0; k < nals; k++) begin
                repeat ($urandom_range(3) == 0 ? $urandom_range(3, 5) : 2)
                    au.insert(au.size(), 8'h00);
                au.insert(au.size(), 8'h01);
                if ($urandom_range(9) != 0) begin
                    au.insert(au.size(), pick_header());
                    plen = ($urandom_range(9) == 0 && max_payload > 12) ?
                           $urandom_range(13, max_payload) :
                           $urandom_range(0, max_payload < 12 ? max_payload : 12);
                    repeat (plen)
                        au.insert(au.size(),
                                  $urandom_range(4) == 0 ? 8'h00 : 8'($urandom));
                end
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) au.insert(au.size(), 8'h00);
            if (au.size() == 0) au.insert(au.size(), 8'($urandom));
        end
        queue_au(au);
        n_bytes = au.size();
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sc_mode = val[1:0];
    endtask

    task automatic set_codec(input logic [1:0] mode);
        reg_write({ansc_pkg::REG_CODEC_MODE, 2'b00}, {30'd0, mode});
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (au_bytes_q.size() != 0 || s_tvalid || nal_records_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [7:0] dir[$];
        int sent;
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset codec mode: dropped parameter sets, extra leading zero,
        // empty unit, start code on the closing byte
        dir = '{8'h55, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h01, 8'h68, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00,
                8'h00, 8'h01};
        queue_au(dir);
        // closing with no start code at all
        dir = '{8'h80};
        queue_au(dir);
        // unit of one byte that also closes the access unit, header zero
        dir = '{8'h00, 8'h00, 8'h01, 8'h00};
        queue_au(dir);
        wait_drained();

        set_codec(ansc_pkg::CODEC_H265);
        dir = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h40, 8'h01, 8'h00, 8'h00, 8'h01, 8'h42,
                8'hFF, 8'h00, 8'h00, 8'h01, 8'hFE, 8'h00};
        queue_au(dir);
        wait_drained();
        set_codec(CODEC_PASS);
        queue_au(dir);
        wait_drained();
        set_codec(CODEC_PASS_ALT);
        queue_au(dir);
        wait_drained();

        // output held off while the source streams short units with no gaps
        set_codec(CODEC_PASS);
        idle_on  = 1'b0;
        hold_req = ~hold_req;
        sent = 0;
        while (sent < 250) begin
            queue_random_au(1, n);
            sent += n;
        end
        wait_drained();
        idle_on = 1'b1;

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            set_codec(2'($urandom_range(3)));
            repeat ($urandom_range(3, 10)) begin
                queue_random_au(60, n);
                sent += n;
            end
            wait_drained();
        end

        if (mismatches == 0 && nal_records_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ansc_pkg.sv
rtl/ansc_front.sv
rtl/ansc_fifo.sv
rtl/ansc_back.sv
rtl/annexb_nal_unit_scanner_core.sv
rtl/ansc_checker.sv
bench/annexb_nal_unit_scanner_core_tb.sv
